>>> src/temp_pressure_compensation_defines.svh
`ifndef TEMP_PRESSURE_COMPENSATION_DEFINES_SVH
`define TEMP_PRESSURE_COMPENSATION_DEFINES_SVH

// same-cycle implication on clk, quiet while arst_n is low
`define TPC_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication on clk, quiet while arst_n is low
`define TPC_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> src/tpc_pkg.sv
package tpc_pkg;

	localparam int ADC_W  = 20;
	localparam int CAL_W  = 16;
	localparam int TEMP_W = 15;
	localparam int PRES_W = 24;
	localparam int NUM_W  = 64;
	localparam int DEN_W  = 31;

	localparam logic signed [TEMP_W-1:0] TEMP_MIN = -15'sd4000;
	localparam logic signed [TEMP_W-1:0] TEMP_MAX = 15'sd8500;
	localparam logic [PRES_W-1:0]        PRES_MAX = 24'hFFFFFF;
	localparam logic signed [25:0]       FINE_OFS = 26'sd128000;
	localparam logic [ADC_W:0]           P_BASE   = 21'd1048576;
	localparam logic [11:0]              K_3125   = 12'd3125;
	localparam logic [63:0]              HALF_47  = 64'h0000_8000_0000_0000;

	// configuration register indexes
	typedef enum logic [1:0] {
		CFG_TEMP   = 2'd0,
		CFG_PRES_A = 2'd1,
		CFG_PRES_B = 2'd2,
		CFG_PRES_C = 2'd3
	} cfg_idx_t;

	// unpacked calibration words
	typedef struct packed {
		logic [CAL_W-1:0]        t1;
		logic signed [CAL_W-1:0] t2;
		logic signed [CAL_W-1:0] t3;
		logic [CAL_W-1:0]        p1;
		logic signed [CAL_W-1:0] p2;
		logic signed [CAL_W-1:0] p3;
		logic signed [CAL_W-1:0] p4;
		logic signed [CAL_W-1:0] p5;
		logic signed [CAL_W-1:0] p6;
		logic signed [CAL_W-1:0] p7;
		logic signed [CAL_W-1:0] p8;
		logic signed [CAL_W-1:0] p9;
	} cal_t;

	// item handed from front to back
	typedef struct packed {
		logic signed [TEMP_W-1:0] temp;
		logic                     dz;
		logic                     q_neg;
		logic [NUM_W-1:0]         num;
		logic [DEN_W-1:0]         den;
	} mid_t;

	// fields riding alongside the divider
	typedef struct packed {
		logic signed [TEMP_W-1:0] temp;
		logic                     dz;
		logic                     q_neg;
	} side_t;

	// finished result
	typedef struct packed {
		logic signed [TEMP_W-1:0] temp;
		logic [PRES_W-1:0]        pa;
		logic                     dz;
	} res_t;

endpackage

>>> src/temp_pressure_compensation.sv
// channel   direction  handshake                  payload
// input     in         push / full                raw_temperature, pressure_raw
// result    out        empty / pop                temperature_centi, pressure_pa, divisor_zero
// config    in         cfg_valid / cfg_ready      cfg_index, cfg_data
//
// One item per cycle sustained while neither queue is full; items pass the front, the middle queue,
// the 64-stage restoring divider (one quotient bit per stage), the back and the result queue.
// Reset clears all calibration registers to zero and empties both queues; no clearing pass.
// full rises when the front-to-back queue fills; the back stops only while the result
// queue is full, the front only while the middle queue is full.
// cfg_ready is always high.
`include "temp_pressure_compensation_defines.svh"

module temp_pressure_compensation import tpc_pkg::*; #(
	parameter int MID_DEPTH = 4,
	parameter int OUT_DEPTH = 2
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     push,
	output logic                     full,
	input  logic [ADC_W-1:0]         raw_temperature,
	input  logic [ADC_W-1:0]         pressure_raw,
	output logic                     empty,
	input  logic                     pop,
	output logic signed [TEMP_W-1:0] temperature_centi,
	output logic [PRES_W-1:0]        pressure_pa,
	output logic                     divisor_zero,
	input  logic                     cfg_valid,
	output logic                     cfg_ready,
	input  logic [1:0]               cfg_index,
	input  logic [63:0]              cfg_data
);

	logic [47:0] temp_cal_q;
	logic [63:0] pres_cal_a_q;
	logic [63:0] pres_cal_b_q;
	logic [15:0] pres_cal_c_q;
	cal_t        cal;

	logic front_en, front_valid;
	mid_t front_data;
	logic mid_full, mid_empty, mid_pop;
	mid_t mid_data;
	logic back_en, back_valid;
	res_t back_data;
	logic out_full;
	res_t out_data;

	assign cfg_ready = 1'b1;

	// calibration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			temp_cal_q   <= '0;
			pres_cal_a_q <= '0;
			pres_cal_b_q <= '0;
			pres_cal_c_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_idx_t'(cfg_index))
				CFG_TEMP:   temp_cal_q   <= cfg_data[47:0];
				CFG_PRES_A: pres_cal_a_q <= cfg_data;
				CFG_PRES_B: pres_cal_b_q <= cfg_data;
				CFG_PRES_C: pres_cal_c_q <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	// unpack calibration words
	assign cal.t1 = temp_cal_q[15:0];
	assign cal.t2 = temp_cal_q[31:16];
	assign cal.t3 = temp_cal_q[47:32];
	assign cal.p1 = pres_cal_a_q[15:0];
	assign cal.p2 = pres_cal_a_q[31:16];
	assign cal.p3 = pres_cal_a_q[47:32];
	assign cal.p4 = pres_cal_a_q[63:48];
	assign cal.p5 = pres_cal_b_q[15:0];
	assign cal.p6 = pres_cal_b_q[31:16];
	assign cal.p7 = pres_cal_b_q[47:32];
	assign cal.p8 = pres_cal_b_q[63:48];
	assign cal.p9 = pres_cal_c_q;

	// front: temperature and pressure coefficients
	assign front_en = !mid_full;
	assign full     = mid_full;

	tpc_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (front_en),
		.in_valid  (push),
		.raw_t     (raw_temperature),
		.raw_p     (pressure_raw),
		.cal       (cal),
		.out_valid (front_valid),
		.out_data  (front_data)
	);

	tpc_fifo #(.W($bits(mid_t)), .DEPTH(MID_DEPTH)) u_mid_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (front_valid && front_en),
		.wdata  (front_data),
		.full   (mid_full),
		.pop    (mid_pop),
		.rdata  (mid_data),
		.empty  (mid_empty)
	);

	// back: division and final correction
	assign back_en = !out_full;
	assign mid_pop = back_en && !mid_empty;

	tpc_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (back_en),
		.in_valid  (!mid_empty),
		.in_data   (mid_data),
		.cal       (cal),
		.out_valid (back_valid),
		.out_data  (back_data)
	);

	tpc_fifo #(.W($bits(res_t)), .DEPTH(OUT_DEPTH)) u_out_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (back_valid && back_en),
		.wdata  (back_data),
		.full   (out_full),
		.pop    (pop),
		.rdata  (out_data),
		.empty  (empty)
	);

	assign temperature_centi = out_data.temp;
	assign pressure_pa       = out_data.pa;
	assign divisor_zero      = out_data.dz;

	`TPC_ASSERT_NOW(a_dz_zero_pa, !empty && divisor_zero, pressure_pa == '0, "pa on zero divisor")
	`TPC_ASSERT_NOW(a_cfg_ready, 1'b1, cfg_ready, "config port not ready")
	`TPC_ASSERT_NEXT(a_head_held, !empty && !pop, !empty && $stable(pressure_pa), "head item lost")

endmodule

>>> src/tpc_fifo.sv
`include "temp_pressure_compensation_defines.svh"

module tpc_fifo #(
	parameter int W     = 8,
	parameter int DEPTH = 4
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  logic [W-1:0] wdata,
	output logic         full,
	input  logic         pop,
	output logic [W-1:0] rdata,
	output logic         empty
);

	// the user must set depth to a power of two, which the block does not enforce; pointers then wrap naturally
	localparam int AW = $clog2(DEPTH);

	logic [W-1:0]  mem [0:DEPTH-1];
	logic [AW-1:0] wr_q;
	logic [AW-1:0] rd_q;
	logic [AW:0]   cnt_q;
	logic          do_push;
	logic          do_pop;

	assign full    = (cnt_q == (AW+1)'(DEPTH));
	assign empty   = (cnt_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem[rd_q];

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push)
				wr_q <= wr_q + AW'(1);
			if (do_pop)
				rd_q <= rd_q + AW'(1);
			if (do_push && !do_pop)
				cnt_q <= cnt_q + (AW+1)'(1);
			else if (do_pop && !do_push)
				cnt_q <= cnt_q - (AW+1)'(1);
		end
	end

	// storage
	always_ff @(posedge clk) begin
		if (do_push)
			mem[wr_q] <= wdata;
	end

	`TPC_ASSERT_NOW(a_push_room, push, !full, "item pushed into a full queue")
	`TPC_ASSERT_NOW(a_cnt_bound, 1'b1, cnt_q <= (AW+1)'(DEPTH), "queue count beyond depth")
	`TPC_ASSERT_NEXT(a_push_shows, push && !pop, !empty, "pushed item not visible")

endmodule

>>> src/tpc_front.sv
module tpc_front import tpc_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  logic             in_valid,
	input  logic [ADC_W-1:0] raw_t,
	input  logic [ADC_W-1:0] raw_p,
	input  cal_t             cal,
	output logic             out_valid,
	output mid_t             out_data
);

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8, v_s9, v_s10, v_s11, v_s12;

	logic signed [17:0] ta_s1;
	logic signed [16:0] tb_s1;
	logic signed [33:0] tat_s2;
	logic signed [33:0] tbb_s2;
	logic signed [22:0] v1t_s3;
	logic signed [37:0] m3_s3;
	logic signed [24:0] fine_s4;
	logic signed [25:0] d_s5;
	logic signed [51:0] dd_s6;
	logic signed [41:0] dp5_s6, dp2_s6, dp5_s7, dp2_s7;
	logic signed [67:0] ddp6_s7, ddp3_s7;
	logic [63:0]        v2_s8, v1p_s8, x_s9, num0_s9;
	logic [47:0]        pl_s10, ph_s10;
	logic [43:0]        nl_s10, nh_s10;
	logic [63:0]        den64_s11, num_s11;
	mid_t               out_s12;

	logic [ADC_W-1:0] pr_s1, pr_s2, pr_s3, pr_s4, pr_s5, pr_s6, pr_s7, pr_s8;
	logic signed [TEMP_W-1:0] temp_s5, temp_s6, temp_s7, temp_s8, temp_s9, temp_s10,
		temp_s11;

	logic signed [27:0]       f5;
	logic signed [27:0]       t5;
	logic signed [19:0]       tq;
	logic signed [TEMP_W-1:0] temp_c;
	logic [ADC_W:0]           pb;
	logic [DEN_W-1:0]         den_w;

	// temperature rounding and saturation
	always_comb begin
		f5 = {{3{fine_s4[24]}}, fine_s4};
		t5 = (f5 <<< 2) + f5 + 28'sd128;
		tq = t5[27:8];
		if (tq < TEMP_MIN)
			temp_c = TEMP_MIN;
		else if (tq > TEMP_MAX)
			temp_c = TEMP_MAX;
		else
			temp_c = tq[TEMP_W-1:0];
	end

	assign pb    = P_BASE - {1'b0, pr_s8};
	assign den_w = den64_s11[63:33];

	// stage valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			{v_s1, v_s2, v_s3, v_s4, v_s5, v_s6} <= '0;
			{v_s7, v_s8, v_s9, v_s10, v_s11, v_s12} <= '0;
		end else if (en) begin
			v_s1  <= in_valid;
			v_s2  <= v_s1;
			v_s3  <= v_s2;
			v_s4  <= v_s3;
			v_s5  <= v_s4;
			v_s6  <= v_s5;
			v_s7  <= v_s6;
			v_s8  <= v_s7;
			v_s9  <= v_s8;
			v_s10 <= v_s9;
			v_s11 <= v_s10;
			v_s12 <= v_s11;
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (en) begin
			// temperature differences
			ta_s1 <= {1'b0, raw_t[19:3]} - {1'b0, cal.t1, 1'b0};
			tb_s1 <= {1'b0, raw_t[19:4]} - {1'b0, cal.t1};
			pr_s1 <= raw_p;
			// temperature products
			tat_s2 <= ta_s1 * $signed(cal.t2);
			tbb_s2 <= tb_s1 * tb_s1;
			pr_s2  <= pr_s1;
			v1t_s3 <= tat_s2[33:11];
			m3_s3  <= $signed(tbb_s2[33:12]) * $signed(cal.t3);
			pr_s3  <= pr_s2;
			// fine temperature
			fine_s4 <= {{2{v1t_s3[22]}}, v1t_s3} + {m3_s3[37], m3_s3[37:14]};
			pr_s4   <= pr_s3;
			temp_s5 <= temp_c;
			d_s5    <= {fine_s4[24], fine_s4} - FINE_OFS;
			pr_s5   <= pr_s4;
			// pressure coefficient products
			dd_s6   <= d_s5 * d_s5;
			dp5_s6  <= d_s5 * $signed(cal.p5);
			dp2_s6  <= d_s5 * $signed(cal.p2);
			temp_s6 <= temp_s5;
			pr_s6   <= pr_s5;
			ddp6_s7 <= dd_s6 * $signed(cal.p6);
			ddp3_s7 <= dd_s6 * $signed(cal.p3);
			dp5_s7  <= dp5_s6;
			dp2_s7  <= dp2_s6;
			temp_s7 <= temp_s6;
			pr_s7   <= pr_s6;
			// sums of the coefficient terms
			v2_s8 <= ddp6_s7[63:0] + {{5{dp5_s7[41]}}, dp5_s7, 17'b0}
				+ {{13{cal.p4[15]}}, cal.p4, 35'b0};
			v1p_s8 <= {{8{ddp3_s7[63]}}, ddp3_s7[63:8]} + {{10{dp2_s7[41]}}, dp2_s7, 12'b0};
			temp_s8 <= temp_s7;
			pr_s8   <= pr_s7;
			// divisor base and numerator base
			x_s9    <= HALF_47 + v1p_s8;
			num0_s9 <= {12'b0, pb, 31'b0} - v2_s8;
			temp_s9 <= temp_s8;
			// split products, low word kept
			pl_s10   <= x_s9[31:0] * cal.p1;
			ph_s10   <= x_s9[63:32] * cal.p1;
			nl_s10   <= num0_s9[31:0] * K_3125;
			nh_s10   <= num0_s9[63:32] * K_3125;
			temp_s10 <= temp_s9;
			den64_s11 <= {16'b0, pl_s10} + {ph_s10[31:0], 32'b0};
			num_s11   <= {20'b0, nl_s10} + {nh_s10[31:0], 32'b0};
			temp_s11  <= temp_s10;
			// signs and magnitudes for the divider
			out_s12.temp  <= temp_s11;
			out_s12.dz    <= (den_w == '0);
			out_s12.q_neg <= num_s11[63] ^ den64_s11[63];
			out_s12.num   <= num_s11[63] ? (64'd0 - num_s11) : num_s11;
			out_s12.den   <= den64_s11[63] ? (31'd0 - den_w) : den_w;
		end
	end

	assign out_valid = v_s12;
	assign out_data  = out_s12;

endmodule

>>> src/tpc_div.sv
module tpc_div import tpc_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  logic             in_valid,
	input  logic [NUM_W-1:0] in_num,
	input  logic [DEN_W-1:0] in_den,
	input  side_t            in_side,
	output logic             out_valid,
	output logic [NUM_W-1:0] out_quo,
	output side_t            out_side
);

	// one quotient bit per stage, restoring
	localparam int STEPS = NUM_W;

	logic             v_s    [0:STEPS];
	logic [NUM_W-1:0] dq_s   [0:STEPS];
	side_t            side_s [0:STEPS];
	logic [DEN_W-1:0] rem_s  [0:STEPS-1];
	logic [DEN_W-1:0] den_s  [0:STEPS-1];

	// entry stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s[0] <= 1'b0;
		else if (en)
			v_s[0] <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dq_s[0]   <= in_num;
			side_s[0] <= in_side;
			rem_s[0]  <= '0;
			den_s[0]  <= in_den;
		end
	end

	for (genvar k = 0; k < STEPS; k++) begin : g_step
		logic [DEN_W:0] trial;
		logic [DEN_W:0] diff;
		logic           ge;

		assign trial = {rem_s[k], dq_s[k][NUM_W-1]};
		assign ge    = (trial >= {1'b0, den_s[k]});
		assign diff  = ge ? (trial - {1'b0, den_s[k]}) : trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				v_s[k+1] <= 1'b0;
			else if (en)
				v_s[k+1] <= v_s[k];
		end

		always_ff @(posedge clk) begin
			if (en) begin
				dq_s[k+1]   <= {dq_s[k][NUM_W-2:0], ge};
				side_s[k+1] <= side_s[k];
			end
		end

		// remainder and divisor go no further than the last step
		if (k < STEPS - 1) begin : g_carry
			always_ff @(posedge clk) begin
				if (en) begin
					rem_s[k+1] <= diff[DEN_W-1:0];
					den_s[k+1] <= den_s[k];
				end
			end
		end
	end

	assign out_valid = v_s[STEPS];
	assign out_quo   = dq_s[STEPS];
	assign out_side  = side_s[STEPS];

endmodule

>>> src/tpc_back.sv
module tpc_back import tpc_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic en,
	input  logic in_valid,
	input  mid_t in_data,
	input  cal_t cal,
	output logic out_valid,
	output res_t out_data
);

	side_t            div_side_in;
	side_t            div_side;
	logic             div_valid;
	logic [NUM_W-1:0] div_quo;

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8;
	side_t side_s1, side_s2, side_s3, side_s4, side_s5, side_s6, side_s7;

	logic [63:0]        p_s1, p_s2, p_s3, p_s4, p_s5;
	logic [63:0]        alal_s2;
	logic signed [51:0] alah_s2;
	logic signed [48:0] pl8_s2;
	logic signed [47:0] ph8_s2;
	logic [63:0]        aa_s3, v2_s3, v2_s4, v2_s5;
	logic signed [48:0] al9_s4;
	logic signed [47:0] ah9_s4;
	logic [63:0]        x_s5;
	logic [63:0]        sum_s6;
	logic [63:0]        r_s7;
	res_t               out_s8;

	logic [63:0]       w8;
	logic [PRES_W-1:0] pa_c;

	assign div_side_in = '{temp: in_data.temp, dz: in_data.dz, q_neg: in_data.q_neg};

	tpc_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (in_valid),
		.in_num    (in_data.num),
		.in_den    (in_data.den),
		.in_side   (div_side_in),
		.out_valid (div_valid),
		.out_quo   (div_quo),
		.out_side  (div_side)
	);

	assign w8 = {{15{pl8_s2[48]}}, pl8_s2} + {ph8_s2[31:0], 32'b0};

	// final clamp to whole pascals
	always_comb begin
		if (r_s7[63] || side_s7.dz)
			pa_c = '0;
		else if (r_s7[63:32] != '0)
			pa_c = PRES_MAX;
		else
			pa_c = r_s7[31:8];
	end

	// stage valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			{v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8} <= '0;
		end else if (en) begin
			v_s1 <= div_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
			v_s8 <= v_s7;
		end
	end

	// correction terms on the quotient
	always_ff @(posedge clk) begin
		if (en) begin
			p_s1    <= div_side.q_neg ? (64'd0 - div_quo) : div_quo;
			side_s1 <= div_side;
			// square of p>>>13 and the p8 term, split into words
			alal_s2 <= p_s1[44:13] * p_s1[44:13];
			alah_s2 <= $signed({1'b0, p_s1[44:13]}) * $signed(p_s1[63:45]);
			pl8_s2  <= $signed({1'b0, p_s1[31:0]}) * $signed(cal.p8);
			ph8_s2  <= $signed(p_s1[63:32]) * $signed(cal.p8);
			p_s2    <= p_s1;
			side_s2 <= side_s1;
			aa_s3   <= alal_s2 + {alah_s2[30:0], 33'b0};
			v2_s3   <= {{19{w8[63]}}, w8[63:19]};
			p_s3    <= p_s2;
			side_s3 <= side_s2;
			// p9 times the square
			al9_s4  <= $signed({1'b0, aa_s3[31:0]}) * $signed(cal.p9);
			ah9_s4  <= $signed(aa_s3[63:32]) * $signed(cal.p9);
			v2_s4   <= v2_s3;
			p_s4    <= p_s3;
			side_s4 <= side_s3;
			x_s5    <= {{15{al9_s4[48]}}, al9_s4} + {ah9_s4[31:0], 32'b0};
			v2_s5   <= v2_s4;
			p_s5    <= p_s4;
			side_s5 <= side_s4;
			sum_s6  <= p_s5 + {{25{x_s5[63]}}, x_s5[63:25]} + v2_s5;
			side_s6 <= side_s5;
			r_s7    <= {{8{sum_s6[63]}}, sum_s6[63:8]} + {{44{cal.p7[15]}}, cal.p7, 4'b0};
			side_s7 <= side_s6;
			out_s8.temp <= side_s7.temp;
			out_s8.pa   <= pa_c;
			out_s8.dz   <= side_s7.dz;
		end
	end

	assign out_valid = v_s8;
	assign out_data  = out_s8;

endmodule
